// ===== rtl/core/lim_pkg.sv =====
// Shared types for the prime-field Lagrange interpolation block.
package lim_pkg;

  // Operation broadcast to every coefficient cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLR_SUM,
    CELL_INIT,
    CELL_START,
    CELL_STEP,
    CELL_FIN_BASIS,
    CELL_FIN_SUM,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     op_bit;
  } cell_ctl_t;

endpackage

// ===== rtl/core/lim_mmul.sv =====
// Bit-serial modular multiplier: a * b mod PRIME, one bit of b per cycle.
module lim_mmul import lim_pkg::*; #(
  parameter int PRIME = 251,
  parameter int EW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [EW-1:0] a_i,
  input  logic [EW-1:0] b_i,
  output logic          busy_o,
  output logic [EW-1:0] res_o
);

  localparam int CW = $clog2(EW + 1);
  localparam logic [EW+1:0] P_EXT = (EW + 2)'(PRIME);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [EW-1:0] a_q, b_q, r_q;
  logic [EW+1:0] t0, t1, t2;

  // One shift-and-add step with two conditional subtractions
  always_comb begin
    t0 = {1'b0, r_q, 1'b0} + (b_q[EW-1] ? {2'b00, a_q} : '0);
    t1 = (t0 >= P_EXT) ? t0 - P_EXT : t0;
    t2 = (t1 >= P_EXT) ? t1 - P_EXT : t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(EW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= t2[EW-1:0];
      b_q <= {b_q[EW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign res_o  = r_q;

endmodule

// ===== rtl/core/lim_cell.sv =====
// One coefficient cell: holds a basis and a sum coefficient of one degree.
module lim_cell import lim_pkg::*; #(
  parameter int PRIME    = 251,
  parameter int EW       = 8,
  parameter bit IS_FIRST = 1'b0
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [EW-1:0] prev_b_i,
  input  logic [EW-1:0] next_s_i,
  output logic [EW-1:0] b_o,
  output logic [EW-1:0] s_o
);

  localparam logic [EW+1:0] P_EXT = (EW + 2)'(PRIME);

  logic [EW-1:0] b_q, s_q, c_q, r_q;
  logic [EW+1:0] t0, t1, t2, fa, fs;

  // Serial product step and the closing modular additions
  always_comb begin
    t0 = {1'b0, r_q, 1'b0} + (ctl_i.op_bit ? {2'b00, b_q} : '0);
    t1 = (t0 >= P_EXT) ? t0 - P_EXT : t0;
    t2 = (t1 >= P_EXT) ? t1 - P_EXT : t1;
    fa = {2'b00, r_q} + {2'b00, c_q};
    if (fa >= P_EXT) fa = fa - P_EXT;
    fs = {2'b00, r_q} + {2'b00, s_q};
    if (fs >= P_EXT) fs = fs - P_EXT;
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      CELL_HOLD:      ;
      CELL_CLR_SUM:   s_q <= '0;
      CELL_INIT:      b_q <= IS_FIRST ? EW'(1) : '0;
      CELL_START: begin
        c_q <= prev_b_i;
        r_q <= '0;
      end
      CELL_STEP:      r_q <= t2[EW-1:0];
      CELL_FIN_BASIS: b_q <= fa[EW-1:0];
      CELL_FIN_SUM:   s_q <= fs[EW-1:0];
      CELL_SHIFT:     s_q <= next_s_i;
      default:        ;
    endcase
  end

  assign b_o = b_q;
  assign s_o = s_q;

endmodule

// ===== rtl/core/lagrange_interpolation_modp.sv =====
// Top level: Lagrange interpolation over the integers modulo PRIME.
//
// Points are loaded one per transaction (start high while busy low); each load
// keeps busy high while x and y are reduced bit by bit and written to the
// point memory. The transaction with last_point set, or the MAX_POINTS-th
// one, closes the set. A row of MAX_POINTS cells then builds each basis
// polynomial, all cells multiplying by (x - x_j) in parallel with a
// bit-serial multiplier (W = clog2(PRIME)); a shared serial multiplier forms
// the denominator and its inverse by exponentiation (about 2*W multiplies).
// Then one coefficient per point leaves on consecutive cycles, degree 0 first,
// each on the result ports for one cycle under result_valid_o; the receiver
// cannot stall them.
module lagrange_interpolation_modp import lim_pkg::*; #(
  parameter int PRIME      = 251,
  parameter int MAX_POINTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] x_value_i,
  input  logic [7:0] y_value_i,
  input  logic       last_point_i,
  output logic       result_valid_o,
  output logic [7:0] coefficient_value_o,
  output logic [3:0] coefficient_degree_o,
  output logic       last_coefficient_o,
  output logic       duplicate_x_error_o
);

  localparam int EW   = $clog2(PRIME);
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int BW   = $clog2(EW);
  localparam int OW   = (EW > 8) ? EW : 8;
  localparam int DW   = (NW > 4) ? NW : 4;
  localparam logic [EW:0]   P_E1 = (EW + 1)'(PRIME);
  localparam logic [EW-1:0] P_EW = EW'(PRIME);
  localparam logic [EW-1:0] EXP  = EW'(PRIME - 2);

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_WR, S_CLR, S_IRD, S_ILAT, S_JCHK, S_JRD, S_JGO, S_JRUN,
    S_JFIN, S_JWAIT, S_INV, S_ESQ, S_ESQW, S_EMUL, S_EMULW, S_SCL, S_SCLW,
    S_SGO, S_SRUN, S_SFIN, S_OUT
  } state_e;

  state_e        state_q;
  logic [7:0]    rawx_q, rawy_q;
  logic          last_q;
  logic [2:0]    rcnt_q;
  logic [EW-1:0] rx_q, ry_q;
  logic [NW-1:0] count_q, i_q, j_q, m_q;
  logic [EW-1:0] xi_q, yi_q, denom_q, inv_q, op_q;
  logic [BW-1:0] cnt_q, ebit_q;
  logic          dup_q;
  logic          valid_q, lastc_q, dupo_q;
  logic [7:0]    value_q;
  logic [3:0]    deg_q;

  // Point memory, one read port with registered data
  logic [2*EW-1:0] mem [MAX_POINTS];
  logic [2*EW-1:0] rd_q;
  logic [AW-1:0]   raddr;

  assign raddr = (state_q == S_IRD) ? i_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == S_WR) mem[count_q[AW-1:0]] <= {ry_q, rx_q};
    rd_q <= mem[raddr];
  end

  // Input reduction steps
  logic [EW:0] rx2, ry2;
  always_comb begin
    rx2 = {rx_q, rawx_q[7]};
    if (rx2 >= P_E1) rx2 = rx2 - P_E1;
    ry2 = {ry_q, rawy_q[7]};
    if (ry2 >= P_E1) ry2 = ry2 - P_E1;
  end

  // Difference x_i - x_j and the negated x_j
  logic [EW-1:0] xj, negx;
  logic [EW:0]   diff;
  always_comb begin
    xj   = rd_q[EW-1:0];
    negx = (xj == '0) ? '0 : P_EW - xj;
    diff = {1'b0, xi_q} + {1'b0, negx};
    if (diff >= P_E1) diff = diff - P_E1;
  end

  // Shared serial multiplier
  logic          mm_start, mm_busy;
  logic [EW-1:0] mm_a, mm_b, mm_res;

  always_comb begin
    mm_start = 1'b0;
    mm_a     = inv_q;
    mm_b     = inv_q;
    unique case (state_q)
      S_JGO: begin
        mm_start = 1'b1;
        mm_a     = denom_q;
        mm_b     = diff[EW-1:0];
      end
      S_ESQ:  mm_start = 1'b1;
      S_EMUL: begin
        mm_start = 1'b1;
        mm_b     = denom_q;
      end
      S_SCL: begin
        mm_start = 1'b1;
        mm_a     = yi_q;
      end
      default: ;
    endcase
  end

  lim_mmul #(.PRIME(PRIME), .EW(EW)) u_mmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .busy_o (mm_busy),
    .res_o  (mm_res)
  );

  // Cell row control
  cell_ctl_t ctl;
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.op_bit = op_q[cnt_q];
    unique case (state_q)
      S_CLR:          ctl.op = CELL_CLR_SUM;
      S_IRD:          ctl.op = CELL_INIT;
      S_JGO, S_SGO:   ctl.op = CELL_START;
      S_JRUN, S_SRUN: ctl.op = CELL_STEP;
      S_JFIN:         ctl.op = CELL_FIN_BASIS;
      S_SFIN:         ctl.op = CELL_FIN_SUM;
      S_OUT:          ctl.op = CELL_SHIFT;
      default:        ;
    endcase
  end

  logic [EW-1:0] b_w [MAX_POINTS];
  logic [EW-1:0] s_w [MAX_POINTS];

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    logic [EW-1:0] prev_b, next_s;
    if (g == 0) begin : g_first
      assign prev_b = '0;
    end else begin : g_rest
      assign prev_b = b_w[g-1];
    end
    if (g == MAX_POINTS - 1) begin : g_end
      assign next_s = '0;
    end else begin : g_mid
      assign next_s = s_w[g+1];
    end
    lim_cell #(.PRIME(PRIME), .EW(EW), .IS_FIRST(g == 0)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .prev_b_i(prev_b),
      .next_s_i(next_s),
      .b_o     (b_w[g]),
      .s_o     (s_w[g])
    );
  end

  logic [OW-1:0] s0_ext;
  logic [DW-1:0] m_ext;
  assign s0_ext = OW'(s_w[0]);
  assign m_ext  = DW'(m_q);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      cnt_q   <= '0;
      ebit_q  <= '0;
      rcnt_q  <= '0;
      dup_q   <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          rawx_q  <= x_value_i;
          rawy_q  <= y_value_i;
          last_q  <= last_point_i;
          rx_q    <= '0;
          ry_q    <= '0;
          rcnt_q  <= 3'd7;
          state_q <= S_RED;
        end
        S_RED: begin
          rx_q   <= rx2[EW-1:0];
          ry_q   <= ry2[EW-1:0];
          rawx_q <= {rawx_q[6:0], 1'b0};
          rawy_q <= {rawy_q[6:0], 1'b0};
          rcnt_q <= rcnt_q - 1'b1;
          if (rcnt_q == '0) state_q <= S_WR;
        end
        S_WR: begin
          count_q <= count_q + 1'b1;
          if (last_q || (count_q + 1'b1 == NW'(MAX_POINTS))) state_q <= S_CLR;
          else state_q <= S_IDLE;
        end
        S_CLR: begin
          i_q     <= '0;
          dup_q   <= 1'b0;
          state_q <= S_IRD;
        end
        S_IRD: begin
          denom_q <= EW'(1);
          j_q     <= '0;
          state_q <= S_ILAT;
        end
        S_ILAT: begin
          xi_q    <= rd_q[EW-1:0];
          yi_q    <= rd_q[2*EW-1:EW];
          state_q <= S_JCHK;
        end
        S_JCHK: begin
          if (j_q == count_q) state_q <= S_INV;
          else if (j_q == i_q) j_q <= j_q + 1'b1;
          else state_q <= S_JRD;
        end
        S_JRD: state_q <= S_JGO;
        S_JGO: begin
          op_q    <= negx;
          cnt_q   <= BW'(EW - 1);
          state_q <= S_JRUN;
        end
        S_JRUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_JFIN;
        end
        S_JFIN: state_q <= S_JWAIT;
        S_JWAIT: if (!mm_busy) begin
          denom_q <= mm_res;
          j_q     <= j_q + 1'b1;
          state_q <= S_JCHK;
        end
        S_INV: begin
          if (denom_q == '0) begin
            dup_q   <= 1'b1;
            m_q     <= '0;
            state_q <= S_OUT;
          end else begin
            inv_q   <= EW'(1);
            ebit_q  <= BW'(EW - 1);
            state_q <= S_ESQ;
          end
        end
        S_ESQ: state_q <= S_ESQW;
        S_ESQW: if (!mm_busy) begin
          inv_q <= mm_res;
          if (EXP[ebit_q]) state_q <= S_EMUL;
          else if (ebit_q == '0) state_q <= S_SCL;
          else begin
            ebit_q  <= ebit_q - 1'b1;
            state_q <= S_ESQ;
          end
        end
        S_EMUL: state_q <= S_EMULW;
        S_EMULW: if (!mm_busy) begin
          inv_q <= mm_res;
          if (ebit_q == '0) state_q <= S_SCL;
          else begin
            ebit_q  <= ebit_q - 1'b1;
            state_q <= S_ESQ;
          end
        end
        S_SCL: state_q <= S_SCLW;
        S_SCLW: if (!mm_busy) begin
          op_q    <= mm_res;
          state_q <= S_SGO;
        end
        S_SGO: begin
          cnt_q   <= BW'(EW - 1);
          state_q <= S_SRUN;
        end
        S_SRUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_SFIN;
        end
        S_SFIN: begin
          i_q <= i_q + 1'b1;
          if (i_q + 1'b1 == count_q) begin
            m_q     <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_IRD;
          end
        end
        S_OUT: begin
          valid_q <= 1'b1;
          value_q <= dup_q ? 8'd0 : s0_ext[7:0];
          deg_q   <= m_ext[3:0];
          lastc_q <= (m_q + 1'b1 == count_q);
          dupo_q  <= dup_q;
          m_q     <= m_q + 1'b1;
          if (m_q + 1'b1 == count_q) begin
            count_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy                 = (state_q != S_IDLE);
  assign result_valid_o       = valid_q;
  assign coefficient_value_o  = value_q;
  assign coefficient_degree_o = deg_q;
  assign last_coefficient_o   = lastc_q;
  assign duplicate_x_error_o  = dupo_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the prime-field Lagrange interpolation block.
`timescale 1ns / 1ps

module testbench;

  localparam int PRIME      = 251;
  localparam int MAX_POINTS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic       last;
  } point_t;

  typedef struct packed {
    logic [7:0] value;
    logic [3:0] degree;
    logic       last;
    logic       dup;
  } coeff_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] x_value_i = '0;
  logic [7:0] y_value_i = '0;
  logic       last_point_i = 1'b0;
  logic       result_valid_o;
  logic [7:0] coefficient_value_o;
  logic [3:0] coefficient_degree_o;
  logic       last_coefficient_o;
  logic       duplicate_x_error_o;

  lagrange_interpolation_modp uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  point_t pending_points[$];
  coeff_t expected_coeffs[$];
  int     idle_percent = 0;
  int     mismatches = 0;
  int     cycles = 0;

  // Point memory of the predictor
  int px[MAX_POINTS];
  int py[MAX_POINTS];
  int held = 0;

  function automatic int fmul(int a, int b);
    return (a * b) % PRIME;
  endfunction

  function automatic int finv(int a);
    int r, b, e;
    r = 1; b = a % PRIME; e = PRIME - 2;
    while (e != 0) begin
      if (e & 1) r = fmul(r, b);
      b = fmul(b, b);
      e >>= 1;
    end
    return r;
  endfunction

  // Predict one accepted transaction; closes a set when flagged or full
  task automatic predict_point(point_t p);
    int k, deg, negx, den, scl;
    bit dup;
    int sum[MAX_POINTS];
    int basis[MAX_POINTS + 1];
    coeff_t c;
    px[held] = p.x % PRIME;
    py[held] = p.y % PRIME;
    held++;
    k = held;
    if (!p.last && k < MAX_POINTS) return;
    dup = 1'b0;
    for (int i = 0; i < k; i++)
      for (int j = i + 1; j < k; j++)
        if (px[i] == px[j]) dup = 1'b1;
    for (int m = 0; m < MAX_POINTS; m++) sum[m] = 0;
    if (!dup) begin
      for (int i = 0; i < k; i++) begin
        for (int m = 0; m <= MAX_POINTS; m++) basis[m] = 0;
        basis[0] = 1; deg = 0; den = 1;
        for (int j = 0; j < k; j++) begin
          if (j == i) continue;
          negx = (PRIME - px[j]) % PRIME;
          for (int m = deg + 1; m > 0; m--)
            basis[m] = (basis[m-1] + fmul(basis[m], negx)) % PRIME;
          basis[0] = fmul(basis[0], negx);
          deg++;
          den = fmul(den, (px[i] + negx) % PRIME);
        end
        scl = fmul(py[i], finv(den));
        for (int m = 0; m < k; m++) sum[m] = (sum[m] + fmul(basis[m], scl)) % PRIME;
      end
    end
    for (int m = 0; m < k; m++) begin
      c.value = 8'(sum[m]); c.degree = 4'(m); c.last = (m == k - 1); c.dup = dup;
      expected_coeffs.push_back(c);
    end
    held = 0;
  endtask

  // Driver: one transaction per accept, with random idling
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_point({x_value_i, y_value_i, last_point_i});
      if (!start || !busy) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= idle_percent) begin
          point_t p;
          p = pending_points.pop_front();
          start <= 1'b1;
          x_value_i <= p.x;
          y_value_i <= p.y;
          last_point_i <= p.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every strobed coefficient with the oldest prediction
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) begin
      coeff_t got, exp_c;
      got = {coefficient_value_o, coefficient_degree_o, last_coefficient_o,
             duplicate_x_error_o};
      if (expected_coeffs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected coefficient %p", got);
      end else begin
        exp_c = expected_coeffs.pop_front();
        if (got !== exp_c) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_c, got);
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[lagrange_interpolation_modp] ERROR");
      $finish;
    end
  end

  function automatic point_t rand_point(bit last);
    point_t p;
    p.x = 8'($urandom_range(255));
    p.y = 8'($urandom_range(255));
    p.last = last;
    return p;
  endfunction

  // Queue a well-formed set of k points, with distinct reduced x unless allow_dup
  task automatic queue_set(int k, bit allow_dup);
    int used[$];
    point_t p;
    for (int i = 0; i < k; i++) begin
      p = rand_point((i == k - 1) && (k < MAX_POINTS || $urandom_range(1)));
      if (!allow_dup) begin
        while ((p.x % PRIME) inside {used}) p.x = 8'($urandom_range(255));
        used.push_back(p.x % PRIME);
      end
      pending_points.push_back(p);
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || start || busy || expected_coeffs.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int total, k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: single point, extremes, out-of-range reduction, duplicates, full set
    pending_points.push_back('{8'd0, 8'd250, 1'b1});
    pending_points.push_back('{8'd255, 8'd255, 1'b1});
    pending_points.push_back('{8'd250, 8'd0, 1'b0});
    pending_points.push_back('{8'd0, 8'd255, 1'b1});
    pending_points.push_back('{8'd3, 8'd7, 1'b0});
    pending_points.push_back('{8'd254, 8'd9, 1'b1});
    pending_points.push_back('{8'd1, 8'd1, 1'b0});
    pending_points.push_back('{8'd2, 8'd4, 1'b0});
    pending_points.push_back('{8'd3, 8'd9, 1'b1});
    for (int i = 0; i < MAX_POINTS; i++)
      pending_points.push_back('{8'(i * 15 + 5), 8'($urandom_range(255)), 1'b0});
    wait_drained();
    total = 25;
    for (int ph = 0; ph < 4; ph++) begin
      idle_percent = (ph == 0) ? 0 : (ph == 1) ? 50 : (ph == 2) ? 0 : 24;
      while (total < 25 + (ph + 1) * 106) begin
        k = ($urandom_range(9) == 0) ? MAX_POINTS : $urandom_range(1, 6);
        queue_set(k, $urandom_range(9) == 0);
        total += k;
      end
      wait_drained();
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_coeffs.size() == 0) begin
      $display("[lagrange_interpolation_modp] OK");
    end else begin
      $display("[lagrange_interpolation_modp] ERROR");
    end
    $finish;
  end

endmodule
